// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the matrix sum/product RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, switched off while in reset.
`define MXSP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mxsp assertion failed");

// Condition that must never hold, outside reset.
`define MXSP_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mxsp forbidden condition seen");

`endif

// ===== rtl/core/mxsp_pkg.sv =====
// Shared types and codes for the matrix sum/product block.
package mxsp_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned REG_W  = 4;

    // Input commands
    typedef enum logic [2:0] {
        CMD_LOAD_A  = 3'd0,
        CMD_LOAD_B  = 3'd1,
        CMD_LOAD_C  = 3'd2,
        CMD_LOAD_D  = 3'd3,
        CMD_COMPUTE = 3'd4
    } cmd_t;

    // Result kinds
    localparam logic [1:0] KIND_SUM_E   = 2'd0;
    localparam logic [1:0] KIND_SUM_F   = 2'd1;
    localparam logic [1:0] KIND_PRODUCT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROWS_LEFT  = 2'd0;
    localparam logic [1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [1:0] CFG_COLS_RIGHT = 2'd2;

    // Operand tag travelling with the store read data into the MAC
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

// ===== rtl/core/mxsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mxsp_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/mxsp_mac.sv =====
// Shared multiply-accumulate unit: registered 32x32 multiply, then wrapping accumulate.
module mxsp_mac (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mxsp_pkg::mac_ctl_t          op_ctl,
    input  logic [mxsp_pkg::DATA_W-1:0] op_a,
    input  logic [mxsp_pkg::DATA_W-1:0] op_b,
    output logic [mxsp_pkg::DATA_W-1:0] acc,
    output logic                        done
);

    localparam int unsigned W = mxsp_pkg::DATA_W;

    logic [2*W-1:0]     full_prod;
    logic [W-1:0]       prod_reg;
    mxsp_pkg::mac_ctl_t prod_ctl_reg;
    logic [W-1:0]       acc_reg;
    logic [W-1:0]       acc_next;
    logic               done_reg;

    // Only the low word of the product matters (modulo 2^32)
    assign full_prod = {{W{1'b0}}, op_a} * {{W{1'b0}}, op_b};

    // Multiply stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_ctl_reg <= '0;
        end else begin
            prod_ctl_reg <= op_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (op_ctl.valid) begin
            prod_reg <= full_prod[W-1:0];
        end
    end

    // Accumulate stage, cleared by the first term of a dot product
    assign acc_next = (prod_ctl_reg.first ? '0 : acc_reg) + prod_reg;

    always_ff @(posedge aclk) begin
        if (prod_ctl_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= prod_ctl_reg.valid & prod_ctl_reg.last;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// ===== rtl/core/matrix_sum_product.sv =====
// Top level of the matrix sum/product block: config, sequencer, stores and MAC.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    command, row_index, col_index, entry_value
//  m_        out        m_valid/m_ready    kind, out_row, out_col, out_value, last
//  cfg_      in         cfg_wr_en          cfg_wr_index, cfg_wr_data
//
// Loads of A or C write the store in their accept cycle. A B or D load reads the store in
// its accept cycle, then adds, writes back and emits from the sum step once m_ is free.
// Compute runs per product entry: one store read per term, a drain through the read and
// MAC registers until the MAC is done, then one emit; with inner_size 0 only the emit.
// Reset is synchronous, active low; the sum stores are not cleared.
// A stalled m_ holds the sequencer at its sum or emit step; s_ready is low while busy.
`include "assert_macros.svh"

module matrix_sum_product #(
    parameter int unsigned MAX_DIM = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_index,
    input  logic [3:0]         cfg_wr_data,
    // input transactions
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_command,
    input  logic [2:0]         s_row_index,
    input  logic [2:0]         s_col_index,
    input  logic signed [31:0] s_entry_value,
    // result transactions
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [3:0]         m_out_row,
    output logic [3:0]         m_out_col,
    output logic signed [31:0] m_out_value,
    output logic               m_last
);

    localparam int unsigned W     = mxsp_pkg::DATA_W;
    localparam int unsigned RW    = mxsp_pkg::REG_W;
    localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned DW    = $clog2(MAX_DIM + 1);
    localparam int unsigned CW    = (DW > 3) ? DW : 3;
    localparam int unsigned XW    = RW + 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SUM   = 5'b00010,
        ST_RUN   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [RW-1:0] rows_left_reg, inner_size_reg, cols_right_reg;
    logic [DW-1:0] nr, ni, nc;

    logic          accept;
    logic          out_free;
    logic          e_ok, f_ok;
    logic [AW-1:0] in_addr;

    // Latched load transaction
    logic [AW-1:0] ld_addr_reg;
    logic [W-1:0]  ld_value_reg;
    logic [2:0]    ld_row_reg, ld_col_reg;
    logic          ld_right_reg;

    // Product loop counters
    logic [DW-1:0] i_reg, j_reg, k_reg;
    logic [DW-1:0] i_next, j_next, k_next;
    logic          k_last, j_last, i_last;

    // Store ports
    logic          l_we, r_we, l_re, r_re;
    logic [AW-1:0] l_waddr, r_waddr, l_raddr, r_raddr;
    logic [W-1:0]  l_wdata, r_wdata, l_rdata, r_rdata;
    logic [W-1:0]  sum_value;

    mxsp_pkg::mac_ctl_t rd_ctl_reg, rd_ctl_next;
    logic [W-1:0]       mac_acc;
    logic               mac_done;

    // Output register
    logic          m_valid_reg;
    logic [1:0]    m_kind_reg;
    logic [3:0]    m_row_reg, m_col_reg;
    logic [W-1:0]  m_value_reg;
    logic          m_last_reg;
    logic          emit_sum, emit_prod;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_left_reg  <= RW'(1);
            inner_size_reg <= RW'(1);
            cols_right_reg <= RW'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                mxsp_pkg::CFG_ROWS_LEFT:  rows_left_reg  <= cfg_wr_data;
                mxsp_pkg::CFG_INNER_SIZE: inner_size_reg <= cfg_wr_data;
                mxsp_pkg::CFG_COLS_RIGHT: cols_right_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Dimensions clamped to MAX_DIM
    assign nr = ({1'b0, rows_left_reg} > XW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(rows_left_reg);
    assign ni = ({1'b0, inner_size_reg} > XW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(inner_size_reg);
    assign nc = ({1'b0, cols_right_reg} > XW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cols_right_reg);

    // Handshakes
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid & s_ready;
    assign out_free = ~m_valid_reg | m_ready;

    // Load range checks and store address
    assign e_ok    = (CW'(s_row_index) < CW'(nr)) && (CW'(s_col_index) < CW'(ni));
    assign f_ok    = (CW'(s_row_index) < CW'(ni)) && (CW'(s_col_index) < CW'(nc));
    assign in_addr = AW'(int'(s_row_index) * MAX_DIM + int'(s_col_index));

    // Loop bounds
    assign k_last = (k_reg + DW'(1) == ni);
    assign j_last = (j_reg + DW'(1) == nc);
    assign i_last = (i_reg + DW'(1) == nr);

    assign sum_value = (ld_right_reg ? r_rdata : l_rdata) + ld_value_reg;
    assign emit_sum  = (state_reg == ST_SUM) & out_free;
    assign emit_prod = (state_reg == ST_EMIT) & out_free;

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        rd_ctl_next = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_command)
                        mxsp_pkg::CMD_LOAD_B: if (e_ok) state_next = ST_SUM;
                        mxsp_pkg::CMD_LOAD_D: if (f_ok) state_next = ST_SUM;
                        mxsp_pkg::CMD_COMPUTE: begin
                            i_next = '0;
                            j_next = '0;
                            k_next = '0;
                            if (nr != '0 && nc != '0) begin
                                state_next = (ni == '0) ? ST_EMIT : ST_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SUM: begin
                if (out_free) state_next = ST_IDLE;
            end
            ST_RUN: begin
                // one store read per term
                rd_ctl_next.valid = 1'b1;
                rd_ctl_next.first = (k_reg == '0);
                rd_ctl_next.last  = k_last;
                if (k_last) begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + DW'(1);
                end
            end
            ST_DRAIN: begin
                if (mac_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (i_last && j_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        if (j_last) begin
                            j_next = '0;
                            i_next = i_reg + DW'(1);
                        end else begin
                            j_next = j_reg + DW'(1);
                        end
                        state_next = (ni == '0) ? ST_EMIT : ST_RUN;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            rd_ctl_reg <= '0;
        end else begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            rd_ctl_reg <= rd_ctl_next;
        end
    end

    // Latch every accepted transaction; the partner load uses it
    always_ff @(posedge aclk) begin
        if (accept) begin
            ld_addr_reg  <= in_addr;
            ld_value_reg <= s_entry_value;
            ld_row_reg   <= s_row_index;
            ld_col_reg   <= s_col_index;
            ld_right_reg <= (s_command == mxsp_pkg::CMD_LOAD_D);
        end
    end

    // Left store port control (A, E)
    always_comb begin
        l_we    = 1'b0;
        l_waddr = in_addr;
        l_wdata = s_entry_value;
        if (accept && s_command == mxsp_pkg::CMD_LOAD_A && e_ok) begin
            l_we = 1'b1;
        end else if (emit_sum && !ld_right_reg) begin
            l_we    = 1'b1;
            l_waddr = ld_addr_reg;
            l_wdata = sum_value;
        end
    end

    // Right store port control (C, F)
    always_comb begin
        r_we    = 1'b0;
        r_waddr = in_addr;
        r_wdata = s_entry_value;
        if (accept && s_command == mxsp_pkg::CMD_LOAD_C && f_ok) begin
            r_we = 1'b1;
        end else if (emit_sum && ld_right_reg) begin
            r_we    = 1'b1;
            r_waddr = ld_addr_reg;
            r_wdata = sum_value;
        end
    end

    // Read addresses: partner load from the input, product terms from the counters
    always_comb begin
        if (state_reg == ST_RUN) begin
            l_re    = 1'b1;
            r_re    = 1'b1;
            l_raddr = AW'(int'(i_reg) * MAX_DIM + int'(k_reg));
            r_raddr = AW'(int'(k_reg) * MAX_DIM + int'(j_reg));
        end else begin
            l_re    = accept && s_command == mxsp_pkg::CMD_LOAD_B && e_ok;
            r_re    = accept && s_command == mxsp_pkg::CMD_LOAD_D && f_ok;
            l_raddr = in_addr;
            r_raddr = in_addr;
        end
    end

    mxsp_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_left_store (
        .aclk    (aclk),
        .wr_en   (l_we),
        .wr_addr (l_waddr),
        .wr_data (l_wdata),
        .rd_en   (l_re),
        .rd_addr (l_raddr),
        .rd_data (l_rdata)
    );

    mxsp_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_right_store (
        .aclk    (aclk),
        .wr_en   (r_we),
        .wr_addr (r_waddr),
        .wr_data (r_wdata),
        .rd_en   (r_re),
        .rd_addr (r_raddr),
        .rd_data (r_rdata)
    );

    mxsp_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op_ctl  (rd_ctl_reg),
        .op_a    (l_rdata),
        .op_b    (r_rdata),
        .acc     (mac_acc),
        .done    (mac_done)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_sum || emit_prod) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_sum) begin
            m_kind_reg  <= ld_right_reg ? mxsp_pkg::KIND_SUM_F : mxsp_pkg::KIND_SUM_E;
            m_row_reg   <= 4'(ld_row_reg) + 4'd1;
            m_col_reg   <= 4'(ld_col_reg) + 4'd1;
            m_value_reg <= sum_value;
            m_last_reg  <= 1'b1;
        end else if (emit_prod) begin
            m_kind_reg  <= mxsp_pkg::KIND_PRODUCT;
            m_row_reg   <= 4'(i_reg + DW'(1));
            m_col_reg   <= 4'(j_reg + DW'(1));
            m_value_reg <= (ni == '0) ? '0 : mac_acc;
            m_last_reg  <= i_last & j_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_out_row   = m_row_reg;
    assign m_out_col   = m_col_reg;
    assign m_out_value = $signed(m_value_reg);
    assign m_last      = m_last_reg;

    // A finished dot product only arrives while the sequencer waits for it
    `MXSP_ASSERT(a_done_in_drain, aclk, aresetn, mac_done |-> (state_reg == ST_DRAIN))
    // No store read for the MAC in flight once the block is ready again
    `MXSP_NEVER(a_idle_no_terms, aclk, aresetn, s_ready && rd_ctl_reg.valid)
    // The final product entry returns the sequencer to idle
    `MXSP_ASSERT(a_last_ends_run, aclk, aresetn, (emit_prod && i_last && j_last) |=> s_ready)

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the matrix sum/product block: directed table, then phases over set and random shapes.
`timescale 1ns / 100ps

module tb;

    localparam int MAX_DIM        = 8;
    localparam int STORE_DEPTH    = MAX_DIM * MAX_DIM;
    localparam int N_ITEMS        = 260;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 64;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
        logic        last;
    } sum_entry_t;

    // One row of the directed table; res is only meaningful when typed and emits are both set
    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        typed;
        logic        emits;
        sum_entry_t  res;
    } stim_row_t;

    localparam sum_entry_t NO_RESULT = '0;
    localparam int N_DIRECTED = 22;

    // Run at the reset dimensions, 1 x 1 x 1
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{mxsp_pkg::CMD_LOAD_A,  3'd0, 3'd0, 32'h7fff_ffff, 1'b1, 1'b0, NO_RESULT},
        '{mxsp_pkg::CMD_LOAD_B,  3'd0, 3'd0, 32'h0000_0001, 1'b1, 1'b1,
          '{mxsp_pkg::KIND_SUM_E, 4'd1, 4'd1, 32'h8000_0000, 1'b1}},
        '{mxsp_pkg::CMD_LOAD_C,  3'd0, 3'd0, 32'h8000_0000, 1'b1, 1'b0, NO_RESULT},
        '{mxsp_pkg::CMD_LOAD_D,  3'd0, 3'd0, 32'h8000_0000, 1'b1, 1'b1,
          '{mxsp_pkg::KIND_SUM_F, 4'd1, 4'd1, 32'h0000_0000, 1'b1}},
        '{mxsp_pkg::CMD_COMPUTE, 3'd7, 3'd7, 32'hffff_ffff, 1'b1, 1'b1,
          '{mxsp_pkg::KIND_PRODUCT, 4'd1, 4'd1, 32'h0000_0000, 1'b1}},
        // loads outside the configured matrices
        '{mxsp_pkg::CMD_LOAD_A,  3'd7, 3'd7, 32'h1234_5678, 1'b1, 1'b0, NO_RESULT},
        '{mxsp_pkg::CMD_LOAD_B,  3'd0, 3'd7, 32'h0000_0005, 1'b1, 1'b0, NO_RESULT},
        '{mxsp_pkg::CMD_LOAD_C,  3'd7, 3'd0, 32'hdead_beef, 1'b1, 1'b0, NO_RESULT},
        '{mxsp_pkg::CMD_LOAD_D,  3'd1, 3'd1, 32'h0000_0007, 1'b1, 1'b0, NO_RESULT},
        // unknown commands
        '{mxsp_pkg::CMD_COMPUTE + 3'd1, 3'd0, 3'd0, 32'hffff_ffff, 1'b1, 1'b0, NO_RESULT},
        '{mxsp_pkg::CMD_COMPUTE + 3'd2, 3'd3, 3'd5, 32'h0000_0000, 1'b1, 1'b0, NO_RESULT},
        '{mxsp_pkg::CMD_COMPUTE + 3'd3, 3'd7, 3'd7, 32'h8000_0000, 1'b1, 1'b0, NO_RESULT},
        // repeated partners add again to the stored sum
        '{mxsp_pkg::CMD_LOAD_B,  3'd0, 3'd0, 32'hffff_ffff, 1'b1, 1'b1,
          '{mxsp_pkg::KIND_SUM_E, 4'd1, 4'd1, 32'h7fff_ffff, 1'b1}},
        '{mxsp_pkg::CMD_LOAD_D,  3'd0, 3'd0, 32'h0000_0003, 1'b1, 1'b1,
          '{mxsp_pkg::KIND_SUM_F, 4'd1, 4'd1, 32'h0000_0003, 1'b1}},
        '{mxsp_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000, 1'b0, 1'b0, NO_RESULT},
        '{mxsp_pkg::CMD_LOAD_A,  3'd0, 3'd0, 32'h8000_0000, 1'b1, 1'b0, NO_RESULT},
        '{mxsp_pkg::CMD_LOAD_B,  3'd0, 3'd0, 32'h0000_0000, 1'b1, 1'b1,
          '{mxsp_pkg::KIND_SUM_E, 4'd1, 4'd1, 32'h8000_0000, 1'b1}},
        '{mxsp_pkg::CMD_LOAD_C,  3'd0, 3'd0, 32'hffff_ffff, 1'b1, 1'b0, NO_RESULT},
        '{mxsp_pkg::CMD_LOAD_D,  3'd0, 3'd0, 32'hffff_ffff, 1'b1, 1'b1,
          '{mxsp_pkg::KIND_SUM_F, 4'd1, 4'd1, 32'hffff_fffe, 1'b1}},
        '{mxsp_pkg::CMD_COMPUTE, 3'd2, 3'd6, 32'h5555_aaaa, 1'b0, 1'b0, NO_RESULT},
        '{mxsp_pkg::CMD_LOAD_B,  3'd0, 3'd0, 32'h8000_0000, 1'b1, 1'b1,
          '{mxsp_pkg::KIND_SUM_E, 4'd1, 4'd1, 32'h0000_0000, 1'b1}},
        '{mxsp_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000, 1'b1, 1'b1,
          '{mxsp_pkg::KIND_PRODUCT, 4'd1, 4'd1, 32'h0000_0000, 1'b1}}
    };

    // Opening dimension sets: above the maximum, zero in each place, minimum
    localparam int N_SHAPES = 7;
    localparam logic [3:0] SHAPES [N_SHAPES][3] = '{
        '{4'd15, 4'd1,  4'd15},
        '{4'd1,  4'd15, 4'd1},
        '{4'd0,  4'd3,  4'd2},
        '{4'd2,  4'd0,  4'd3},
        '{4'd3,  4'd2,  4'd0},
        '{4'd0,  4'd0,  4'd0},
        '{4'd1,  4'd1,  4'd1}
    };

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [1:0]         cfg_wr_index  = '0;
    logic [3:0]         cfg_wr_data   = '0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [2:0]         s_command     = '0;
    logic [2:0]         s_row_index   = '0;
    logic [2:0]         s_col_index   = '0;
    logic signed [31:0] s_entry_value = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [1:0]         m_kind;
    logic [3:0]         m_out_row;
    logic [3:0]         m_out_col;
    logic signed [31:0] m_out_value;
    logic               m_last;

    // Mirror of the block's stores and dimensions
    logic [31:0] left_sum  [STORE_DEPTH];
    logic [31:0] right_sum [STORE_DEPTH];
    bit          left_set  [STORE_DEPTH];
    bit          right_set [STORE_DEPTH];
    logic [3:0]  cfg_rows  = 4'd1;
    logic [3:0]  cfg_inner = 4'd1;
    logic [3:0]  cfg_cols  = 4'd1;

    sum_entry_t  pending_entries [$];
    sum_entry_t  want;
    int          errors      = 0;
    int          sent_items  = 0;
    int          idle_cycles = 0;
    int          hold_left   = 0;
    bit          rx_steady   = 1'b0;
    bit          tx_steady   = 1'b0;

    matrix_sum_product #(.MAX_DIM(MAX_DIM)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_row_index   (s_row_index),
        .s_col_index   (s_col_index),
        .s_entry_value (s_entry_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_out_value   (m_out_value),
        .m_last        (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            4: return 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 4'($urandom_range(1, 4));
        if (r < 85) return 4'($urandom_range(5, 8));
        if (r < 93) return 4'd0;
        return 4'($urandom_range(9, 15));
    endfunction

    function automatic int unsigned eff_dim(input logic [3:0] v);
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function automatic logic [3:0] one_based(input int unsigned v);
        return 4'(v + 1);
    endfunction

    // Updates the mirrored stores for one command and, with queue_it set, queues the entries it emits
    function automatic void apply_command(input logic [2:0] cmd, input logic [2:0] row,
                                          input logic [2:0] col, input logic [31:0] value,
                                          input bit queue_it);
        int unsigned nr, ni, nc, idx, i, j, k;
        logic [31:0] acc;
        logic        fin;
        nr  = eff_dim(cfg_rows);
        ni  = eff_dim(cfg_inner);
        nc  = eff_dim(cfg_cols);
        idx = row * MAX_DIM + col;
        case (cmd)
            mxsp_pkg::CMD_LOAD_A, mxsp_pkg::CMD_LOAD_B: begin
                if (row >= nr || col >= ni) return;
                if (cmd == mxsp_pkg::CMD_LOAD_A) begin
                    left_sum[idx] = value;
                    left_set[idx] = 1'b1;
                end else begin
                    left_sum[idx] = left_sum[idx] + value;
                    if (queue_it)
                        pending_entries.push_back({mxsp_pkg::KIND_SUM_E, one_based(row),
                                                   one_based(col), left_sum[idx], 1'b1});
                end
            end
            mxsp_pkg::CMD_LOAD_C, mxsp_pkg::CMD_LOAD_D: begin
                if (row >= ni || col >= nc) return;
                if (cmd == mxsp_pkg::CMD_LOAD_C) begin
                    right_sum[idx] = value;
                    right_set[idx] = 1'b1;
                end else begin
                    right_sum[idx] = right_sum[idx] + value;
                    if (queue_it)
                        pending_entries.push_back({mxsp_pkg::KIND_SUM_F, one_based(row),
                                                   one_based(col), right_sum[idx], 1'b1});
                end
            end
            mxsp_pkg::CMD_COMPUTE: begin
                // row-major walk, dot products wrap at 32 bits
                for (i = 0; i < nr; i++) begin
                    for (j = 0; j < nc; j++) begin
                        acc = '0;
                        for (k = 0; k < ni; k++)
                            acc = acc + left_sum[i * MAX_DIM + k] * right_sum[k * MAX_DIM + j];
                        fin = (i == nr - 1) && (j == nc - 1);
                        if (queue_it)
                            pending_entries.push_back({mxsp_pkg::KIND_PRODUCT, one_based(i),
                                                       one_based(j), acc, fin});
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Presents one transaction and holds it until accepted
    task automatic send_item(input logic [2:0] cmd, input logic [2:0] row,
                             input logic [2:0] col, input logic [31:0] value,
                             input bit queue_it);
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_row_index   <= row;
        s_col_index   <= col;
        s_entry_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_items++;
        apply_command(cmd, row, col, value, queue_it);
    endtask

    task automatic sender_gap();
        int n;
        n = tx_steady ? 0 : gap_len();
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic issue(input logic [2:0] cmd, input logic [2:0] row,
                         input logic [2:0] col, input logic [31:0] value);
        sender_gap();
        send_item(cmd, row, col, value, 1'b1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_entries.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [3:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data  <= value;
        @(posedge aclk);
        if (index == mxsp_pkg::CFG_ROWS_LEFT)
            cfg_rows = value;
        else if (index == mxsp_pkg::CFG_INNER_SIZE)
            cfg_inner = value;
        else if (index == mxsp_pkg::CFG_COLS_RIGHT)
            cfg_cols = value;
    endtask

    // Random load or unknown command; partners only land on written entries
    task automatic send_noise();
        logic [2:0] cmd, row, col;
        int unsigned idx;
        row = 3'($urandom);
        col = 3'($urandom);
        idx = row * MAX_DIM + col;
        if ($urandom_range(0, 2) == 0) begin
            cmd = mxsp_pkg::CMD_COMPUTE + 3'($urandom_range(1, 3));
        end else begin
            cmd = 3'($urandom_range(mxsp_pkg::CMD_LOAD_A, mxsp_pkg::CMD_LOAD_D));
            if (cmd == mxsp_pkg::CMD_LOAD_B && !left_set[idx]) cmd = mxsp_pkg::CMD_LOAD_A;
            if (cmd == mxsp_pkg::CMD_LOAD_D && !right_set[idx]) cmd = mxsp_pkg::CMD_LOAD_C;
        end
        issue(cmd, row, col, rand_value());
    endtask

    // slot: below STORE_DEPTH an E entry, from STORE_DEPTH up an F entry
    task automatic send_partner(input int unsigned slot);
        int unsigned idx;
        logic [2:0] cmd;
        idx = slot % STORE_DEPTH;
        cmd = (slot >= STORE_DEPTH) ? mxsp_pkg::CMD_LOAD_D : mxsp_pkg::CMD_LOAD_B;
        issue(cmd, 3'(idx / MAX_DIM), 3'(idx % MAX_DIM), rand_value());
        if ($urandom_range(0, 7) == 0)
            issue(cmd, 3'(idx / MAX_DIM), 3'(idx % MAX_DIM), rand_value());
    endtask

    // One phase: set dimensions while idle, load the unset entries compute reads and some set ones, then compute
    task automatic run_phase(input logic [3:0] rows, input logic [3:0] inner,
                             input logic [3:0] cols);
        int unsigned nr, ni, nc, n_slots, s, pick, tmp, keep_pct, idx, a, b;
        int unsigned slots [2 * STORE_DEPTH];
        int unsigned deferred [$];
        bit was_set;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_register(mxsp_pkg::CFG_ROWS_LEFT, rows);
        write_register(mxsp_pkg::CFG_INNER_SIZE, inner);
        write_register(mxsp_pkg::CFG_COLS_RIGHT, cols);
        cfg_wr_en <= 1'b0;
        nr = eff_dim(rows);
        ni = eff_dim(inner);
        nc = eff_dim(cols);
        tx_steady = ($urandom_range(0, 3) == 0);

        n_slots = 0;
        for (a = 0; a < nr; a++)
            for (b = 0; b < ni; b++) begin
                slots[n_slots] = a * MAX_DIM + b;
                n_slots++;
            end
        for (a = 0; a < ni; a++)
            for (b = 0; b < nc; b++) begin
                slots[n_slots] = STORE_DEPTH + a * MAX_DIM + b;
                n_slots++;
            end
        for (s = n_slots; s > 1; s--) begin
            pick = $urandom_range(0, s - 1);
            tmp = slots[s - 1];
            slots[s - 1] = slots[pick];
            slots[pick] = tmp;
        end
        // big shapes mostly reuse what earlier phases left in the stores
        keep_pct = (n_slots > 32) ? 10 : 70;

        repeat ($urandom_range(1, 3)) send_noise();
        for (s = 0; s < n_slots; s++) begin
            idx = slots[s] % STORE_DEPTH;
            was_set = (slots[s] >= STORE_DEPTH) ? right_set[idx] : left_set[idx];
            if ($urandom_range(0, 9) == 0) send_noise();
            if (!was_set || $urandom_range(0, 99) < keep_pct)
                issue((slots[s] >= STORE_DEPTH) ? mxsp_pkg::CMD_LOAD_C : mxsp_pkg::CMD_LOAD_A,
                      3'(idx / MAX_DIM), 3'(idx % MAX_DIM), rand_value());
            pick = $urandom_range(0, 9);
            if (pick < 4)
                send_partner(slots[s]);
            else if (pick < 6)
                deferred.push_back(slots[s]);
            if (deferred.size() != 0 && $urandom_range(0, 2) == 0)
                send_partner(deferred.pop_front());
        end
        while (deferred.size() != 0) send_partner(deferred.pop_front());

        // sometimes hold back until every entry so far has come out
        if ($urandom_range(0, 2) == 0) wait_drained();
        issue(mxsp_pkg::CMD_COMPUTE, 3'($urandom), 3'($urandom), rand_value());
        if ($urandom_range(0, 4) == 0)
            issue(mxsp_pkg::CMD_COMPUTE, 3'($urandom), 3'($urandom), rand_value());
    endtask

    // Random shape, kept small once few transactions are left to send
    task automatic random_phase();
        logic [3:0] rows, inner, cols;
        int unsigned slots_est;
        rows  = pick_dim();
        inner = pick_dim();
        cols  = pick_dim();
        slots_est = eff_dim(rows) * eff_dim(inner) + eff_dim(inner) * eff_dim(cols);
        if (2 * slots_est > N_ITEMS - sent_items) begin
            rows  = 4'($urandom_range(1, 3));
            inner = 4'($urandom_range(1, 3));
            cols  = 4'($urandom_range(1, 3));
        end
        run_phase(rows, inner, cols);
    endtask

    // Result checking and random back-pressure on the m_ channel
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_entries.size() == 0) begin
                errors++;
                $display("%0t: expected nothing, got kind %0d row %0d col %0d value %h last %0b",
                         $time, m_kind, m_out_row, m_out_col, m_out_value, m_last);
            end else begin
                want = pending_entries.pop_front();
                if (m_kind !== want.kind || m_out_row !== want.row || m_out_col !== want.col ||
                    m_out_value !== want.value || m_last !== want.last) begin
                    errors++;
                    $display("%0t: mismatch: expected kind %0d row %0d col %0d value %h last %0b,",
                             $time, want.kind, want.row, want.col, want.value, want.last,
                             " got kind %0d row %0d col %0d value %h last %0b",
                             m_kind, m_out_row, m_out_col, m_out_value, m_last);
                end
            end
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 2) == 0) hold_left = gap_len();
        end
        if ($urandom_range(0, 199) == 0) rx_steady = !rx_steady;
    end

    // Watchdog: cycles without any transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table at the reset dimensions
        for (n = 0; n < N_DIRECTED; n++) begin
            sender_gap();
            send_item(DIRECTED[n].cmd, DIRECTED[n].row, DIRECTED[n].col, DIRECTED[n].value,
                      !DIRECTED[n].typed);
            if (DIRECTED[n].typed && DIRECTED[n].emits)
                pending_entries.push_back(DIRECTED[n].res);
        end

        for (n = 0; n < N_SHAPES; n++)
            run_phase(SHAPES[n][0], SHAPES[n][1], SHAPES[n][2]);
        while (sent_items < N_ITEMS)
            random_phase();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
